// ===== rtl/midi_to_tone_period_controller_top_assert.svh =====
// Assertion macros used by the controller top level
`ifndef MIDI_TO_TONE_PERIOD_CONTROLLER_TOP_ASSERT_SVH
`define MIDI_TO_TONE_PERIOD_CONTROLLER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge outside reset
`define MTPC_ASSERT(lbl, clk_i, rst_ni, prop, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check that a condition never holds outside reset
`define MTPC_NEVER(lbl, clk_i, rst_ni, cond, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define MTPC_ASSERT(lbl, clk_i, rst_ni, prop, msg)
`define MTPC_NEVER(lbl, clk_i, rst_ni, cond, msg)
`endif

`endif

// ===== rtl/mtpc_pkg.sv =====
// Shared types, codes and constants of the MIDI tone period controller
package mtpc_pkg;

	localparam int NUM_CHANNELS        = 16;
	localparam int DEF_NUM_GENERATORS  = 4;
	localparam int NUM_GEN_REGS        = 4;

	localparam int CH_W      = 4;
	localparam int NOTE_W    = 7;
	localparam int BEND_W    = 14;
	localparam int GEN_W     = 2;
	localparam int ACT_W     = 2;
	localparam int HALF_W    = 17;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 7;
	localparam int MUL_W     = 64;
	localparam int DIV_W     = 14;

	localparam logic [ACT_W-1:0] ACT_NONE  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_STOP  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_START = 2'd2;

	localparam logic [2:0] CMD_NOTE_OFF = 3'd0;
	localparam logic [2:0] CMD_NOTE_ON  = 3'd1;
	localparam logic [2:0] CMD_CONTROL  = 3'd3;
	localparam logic [2:0] CMD_PROGRAM  = 3'd4;
	localparam logic [2:0] CMD_PRESSURE = 3'd5;
	localparam logic [2:0] CMD_BEND     = 3'd6;

	localparam logic [NOTE_W-1:0] CC_SOUND_OFF = 7'd120;
	localparam logic [NOTE_W-1:0] CC_NOTES_OFF = 7'd123;

	localparam logic [BEND_W-1:0] BEND_CENTER = 14'd8192;
	// 69 * 4096 + 8192
	localparam logic signed [20:0] T_BIAS = 21'sd290816;

	localparam logic [MUL_W-1:0] LN2_Q62      = 64'h2C5C85FDF473DE6B;
	localparam logic [MUL_W-1:0] ONE_Q62      = 64'h4000000000000000;
	localparam logic [MUL_W-1:0] HZ_SCALE     = 64'd440;
	localparam logic [MUL_W-1:0] USEC_PER_SEC = 64'd1000000;
	localparam int TAYLOR_TERMS = 24;

	typedef logic [CFG_W-1:0] gen_reset_t [NUM_GEN_REGS];
	localparam gen_reset_t GEN_RESET = '{7'd0, 7'd1, 7'd98, 7'd99};

	typedef enum logic [1:0] {SH_0, SH_40, SH_62} mul_shift_t;

	typedef struct packed {
		logic       start;
		mul_shift_t shift;
	} mul_ctrl_t;

	typedef struct packed {
		logic done;
		logic rem_nz;
	} div_stat_t;

	typedef struct packed {
		logic              start;
		logic [NOTE_W-1:0] note;
		logic [BEND_W-1:0] bend;
	} freq_req_t;

	typedef struct packed {
		logic              done;
		logic [HALF_W-1:0] half;
	} freq_rsp_t;

endpackage

// ===== rtl/mtpc_mul.sv =====
// Shared 64x64 multiplier, one 32x32 partial product per cycle, shifted result
module mtpc_mul (
	input  logic                clk,
	input  logic                arst_n,
	input  mtpc_pkg::mul_ctrl_t ctrl,
	input  logic [63:0]         a,
	input  logic [63:0]         b,
	output logic                done,
	output logic [63:0]         result
);
	import mtpc_pkg::*;

	logic [MUL_W-1:0]   a_q, b_q;
	logic [2*MUL_W-1:0] acc_q;
	logic [MUL_W-1:0]   pp_s1;
	logic [1:0]         pp_pos_s1;
	logic               pp_vld_s1;
	logic [2:0]         cnt_q;
	logic               busy_q;
	logic               done_q;
	mul_shift_t         shift_q;

	logic [31:0]        a_half, b_half;
	logic [MUL_W-1:0]   prod;
	logic [1:0]         pos;
	logic [2*MUL_W-1:0] addend;

	always_comb begin
		a_half = cnt_q[1] ? a_q[63:32] : a_q[31:0];
		b_half = cnt_q[0] ? b_q[63:32] : b_q[31:0];
		prod   = {32'b0, a_half} * {32'b0, b_half};
		pos    = {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
		case (pp_pos_s1)
			2'd1:    addend = {32'b0, pp_s1, 32'b0};
			2'd2:    addend = {pp_s1, 64'b0};
			default: addend = {64'b0, pp_s1};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			cnt_q     <= '0;
			pp_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				a_q     <= a;
				b_q     <= b;
				shift_q <= ctrl.shift;
				acc_q   <= '0;
				cnt_q   <= '0;
				busy_q  <= 1'b1;
			end else if (busy_q) begin
				if (pp_vld_s1)
					acc_q <= acc_q + addend;
				if (cnt_q == 3'd4) begin
					pp_vld_s1 <= 1'b0;
					busy_q    <= 1'b0;
					done_q    <= 1'b1;
				end else begin
					pp_s1     <= prod;
					pp_pos_s1 <= pos;
					pp_vld_s1 <= 1'b1;
					cnt_q     <= cnt_q + 3'd1;
				end
			end
		end
	end

	always_comb begin
		case (shift_q)
			SH_40:   result = acc_q[103:40];
			SH_62:   result = acc_q[125:62];
			default: result = acc_q[63:0];
		endcase
	end

	assign done = done_q;

endmodule

// ===== rtl/mtpc_div.sv =====
// Shared restoring divider, 64-bit dividend, narrow divisor, four bits per cycle
module mtpc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [63:0]         dividend,
	input  logic [13:0]         divisor,
	output mtpc_pkg::div_stat_t stat,
	output logic [63:0]         quotient
);
	import mtpc_pkg::*;

	localparam int STEPS  = 4;
	localparam int CYCLES = MUL_W / STEPS;
	localparam int CNT_W  = $clog2(CYCLES);

	logic [MUL_W-1:0] q_q;
	logic [DIV_W-1:0] rem_q, d_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;

	logic [MUL_W-1:0] q_nx;
	logic [DIV_W-1:0] rem_nx;
	logic [DIV_W:0]   trial;
	logic             fits;

	always_comb begin
		q_nx   = q_q;
		rem_nx = rem_q;
		for (int s = 0; s < STEPS; s++) begin
			trial  = {rem_nx, q_nx[MUL_W-1]};
			fits   = trial >= {1'b0, d_q};
			q_nx   = {q_nx[MUL_W-2:0], fits};
			rem_nx = fits ? DIV_W'(trial - {1'b0, d_q}) : trial[DIV_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				q_q    <= dividend;
				d_q    <= divisor;
				rem_q  <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				q_q   <= q_nx;
				rem_q <= rem_nx;
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(CYCLES - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign stat.done   = done_q;
	assign stat.rem_nz = rem_q != '0;
	assign quotient    = q_q;

endmodule

// ===== rtl/mtpc_freq.sv =====
// Half period sequencer: note and bend to microsecond half period over shared units
module mtpc_freq (
	input  logic                clk,
	input  logic                arst_n,
	input  mtpc_pkg::freq_req_t req,
	output mtpc_pkg::freq_rsp_t rsp
);
	import mtpc_pkg::*;

	typedef enum logic [3:0] {
		F_IDLE, F_QDIV, F_NORM, F_ALIGN, F_Y, F_TMUL, F_TDIV, F_V, F_HDIV
	} fstate_t;

	fstate_t            state_q;
	mul_ctrl_t          mul_ctrl_q;
	logic [MUL_W-1:0]   mul_a_q, mul_b_q;
	logic               div_start_q;
	logic [MUL_W-1:0]   div_dd_q;
	logic [DIV_W-1:0]   div_dv_q;
	logic               neg_q;
	logic [44:0]        m_q;
	logic               g_q, st_q;
	logic [4:0]         k_q;
	logic signed [3:0]  n_q;
	logic [MUL_W-1:0]   y_q, e_q;
	logic [4:0]         kt_q;
	logic               done_q;
	logic [HALF_W-1:0]  half_q;

	logic               mul_done;
	logic [MUL_W-1:0]   mul_res;
	div_stat_t          div_st;
	logic [MUL_W-1:0]   div_quo;

	logic signed [20:0] t;
	logic [20:0]        t_mag;
	logic [44:0]        qa;
	logic [39:0]        frac, frac_sel;
	logic               frac_nz;
	logic signed [3:0]  ip_s, n_nx;
	logic [MUL_W-1:0]   e_nx;
	logic [3:0]         nmag;
	logic [MUL_W-1:0]   hz64;
	logic [DIV_W-1:0]   hz;

	mtpc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mul_ctrl_q),
		.a      (mul_a_q),
		.b      (mul_b_q),
		.done   (mul_done),
		.result (mul_res)
	);

	mtpc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_dd_q),
		.divisor  (div_dv_q),
		.stat     (div_st),
		.quotient (div_quo)
	);

	always_comb begin
		t = $signed({2'b0, req.note, 12'b0}) + $signed({7'b0, req.bend}) - T_BIAS;
		t_mag = t[20] ? 21'(-t) : 21'(t);

		// Q.40 magnitude of the rounded quotient, then floor split
		qa       = 45'(m_q[24:0]) << k_q;
		frac     = qa[39:0];
		frac_nz  = frac != '0;
		ip_s     = 4'(qa[44:40]);
		frac_sel = (neg_q && frac_nz) ? (~frac + 40'd1) : frac;
		n_nx     = neg_q ? (-ip_s - (frac_nz ? 4'sd1 : 4'sd0)) : ip_s;

		e_nx = e_q + div_quo;

		nmag = 4'(-n_q);
		if (n_q[3])
			hz64 = mul_res >> (6'd42 + {2'b0, nmag});
		else
			hz64 = (mul_res << n_q[2:0]) >> 42;
		hz = (hz64[DIV_W-1:0] == '0) ? DIV_W'(1) : hz64[DIV_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= F_IDLE;
			mul_ctrl_q.start <= 1'b0;
			mul_ctrl_q.shift <= SH_0;
			div_start_q      <= 1'b0;
			done_q           <= 1'b0;
		end else begin
			mul_ctrl_q.start <= 1'b0;
			div_start_q      <= 1'b0;
			done_q           <= 1'b0;
			case (state_q)
				F_IDLE: begin
					if (req.start) begin
						neg_q       <= t[20];
						div_dd_q    <= {18'b0, t_mag[18:0], 27'b0};
						div_dv_q    <= DIV_W'(3);
						div_start_q <= 1'b1;
						state_q     <= F_QDIV;
					end
				end
				F_QDIV: begin
					// quotient carries one extra fraction bit as the guard
					if (div_st.done) begin
						m_q     <= div_quo[45:1];
						g_q     <= div_quo[0];
						st_q    <= div_st.rem_nz;
						k_q     <= '0;
						state_q <= F_NORM;
					end
				end
				F_NORM: begin
					if (|m_q[44:24]) begin
						st_q <= st_q | g_q;
						g_q  <= m_q[0];
						m_q  <= m_q >> 1;
						k_q  <= k_q + 5'd1;
					end else begin
						// round to nearest even
						m_q     <= m_q + 45'(g_q && (st_q || m_q[0]));
						state_q <= F_ALIGN;
					end
				end
				F_ALIGN: begin
					n_q              <= n_nx;
					mul_a_q          <= {24'b0, frac_sel};
					mul_b_q          <= LN2_Q62;
					mul_ctrl_q.start <= 1'b1;
					mul_ctrl_q.shift <= SH_40;
					state_q          <= F_Y;
				end
				F_Y: begin
					if (mul_done) begin
						y_q              <= mul_res;
						e_q              <= ONE_Q62;
						kt_q             <= 5'd1;
						mul_a_q          <= ONE_Q62;
						mul_b_q          <= mul_res;
						mul_ctrl_q.start <= 1'b1;
						mul_ctrl_q.shift <= SH_62;
						state_q          <= F_TMUL;
					end
				end
				F_TMUL: begin
					if (mul_done) begin
						div_dd_q    <= mul_res;
						div_dv_q    <= {9'b0, kt_q};
						div_start_q <= 1'b1;
						state_q     <= F_TDIV;
					end
				end
				F_TDIV: begin
					if (div_st.done) begin
						e_q              <= e_nx;
						mul_ctrl_q.start <= 1'b1;
						if (kt_q == 5'(TAYLOR_TERMS)) begin
							mul_a_q          <= {20'b0, e_nx[63:20]};
							mul_b_q          <= HZ_SCALE;
							mul_ctrl_q.shift <= SH_0;
							state_q          <= F_V;
						end else begin
							kt_q             <= kt_q + 5'd1;
							mul_a_q          <= div_quo;
							mul_b_q          <= y_q;
							mul_ctrl_q.shift <= SH_62;
							state_q          <= F_TMUL;
						end
					end
				end
				F_V: begin
					if (mul_done) begin
						div_dd_q    <= USEC_PER_SEC;
						div_dv_q    <= hz;
						div_start_q <= 1'b1;
						state_q     <= F_HDIV;
					end
				end
				F_HDIV: begin
					if (div_st.done) begin
						half_q  <= div_quo[HALF_W:1];
						done_q  <= 1'b1;
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.half = half_q;

endmodule

// ===== rtl/midi_to_tone_period_controller_top.sv =====
// Top level: MIDI byte parser, channel state, generator map and result register
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------------
//  in      | in_valid / in_ready   | rx_byte
//  out     | out_valid / out_ready | gen_index, enable_action, period_load, half_period
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A byte with no result leaves the block in T_IDLE; a byte completing a stop item
// passes through T_PUT, which waits for a free result register. A byte completing
// note on or pitch bend first waits in T_CALC for the 24-term series: each term
// is one pass through the shared multiplier and the shared divider, and the
// normalize shifts add to the wait. in_ready is low while busy.
// Reset is asynchronous, active low; cfg_ready is always high.
module midi_to_tone_period_controller_top #(
	parameter int NUM_GENERATORS = mtpc_pkg::DEF_NUM_GENERATORS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [7:0]                       rx_byte,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [mtpc_pkg::GEN_W-1:0]       gen_index,
	output logic [mtpc_pkg::ACT_W-1:0]       enable_action,
	output logic                             period_load,
	output logic [mtpc_pkg::HALF_W-1:0]      half_period,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [mtpc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mtpc_pkg::CFG_W-1:0]       cfg_data
);
	import mtpc_pkg::*;

`include "midi_to_tone_period_controller_top_assert.svh"

	localparam int NUM_GEN_USED =
		(NUM_GENERATORS < NUM_GEN_REGS) ? NUM_GENERATORS : NUM_GEN_REGS;

	typedef enum logic [1:0] {T_IDLE, T_CALC, T_PUT} tstate_t;
	typedef enum logic [1:0] {PH_STATUS, PH_DATA1, PH_DATA2} phase_t;

	tstate_t           state_q;
	phase_t            phase_q;
	logic [6:0]        status_q;
	logic [NOTE_W-1:0] first_q;
	logic [NOTE_W-1:0] note_q [NUM_CHANNELS];
	logic [BEND_W-1:0] bend_q [NUM_CHANNELS];
	logic [CFG_W-1:0]  gen_ch_q [NUM_GEN_USED];
	freq_req_t         freq_req_q;
	freq_rsp_t         freq_rsp;

	logic [GEN_W-1:0]  pend_gen_q;
	logic [ACT_W-1:0]  pend_act_q;
	logic              pend_load_q;
	logic [HALF_W-1:0] pend_half_q;

	logic              out_valid_q;
	logic [GEN_W-1:0]  gen_q;
	logic [ACT_W-1:0]  action_q;
	logic              load_q;
	logic [HALF_W-1:0] half_q;

	logic [CH_W-1:0]   ch;
	logic [2:0]        cmd;
	logic [NOTE_W-1:0] d1, d2;
	logic              is_data;
	logic              found;
	logic [GEN_W-1:0]  gidx;
	logic              fire, calc;
	logic [ACT_W-1:0]  act;
	logic [NOTE_W-1:0] calc_note;
	logic [BEND_W-1:0] calc_bend;

	mtpc_freq u_freq (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (freq_req_q),
		.rsp    (freq_rsp)
	);

	always_comb begin
		ch      = status_q[CH_W-1:0];
		cmd     = status_q[6:4];
		d1      = first_q;
		d2      = rx_byte[6:0];
		is_data = !rx_byte[7];

		// lowest matching generator wins
		found = 1'b0;
		gidx  = '0;
		for (int i = NUM_GEN_USED - 1; i >= 0; i--) begin
			if (gen_ch_q[i] == {3'b0, ch}) begin
				found = 1'b1;
				gidx  = GEN_W'(i);
			end
		end

		fire      = 1'b0;
		calc      = 1'b0;
		act       = ACT_NONE;
		calc_note = note_q[ch];
		calc_bend = bend_q[ch];
		case (cmd)
			CMD_NOTE_ON: begin
				if (d2 != '0) begin
					calc      = 1'b1;
					act       = ACT_START;
					calc_note = d1;
				end else if (d1 == note_q[ch]) begin
					fire = 1'b1;
					act  = ACT_STOP;
				end
			end
			CMD_NOTE_OFF: begin
				if (d1 == note_q[ch]) begin
					fire = 1'b1;
					act  = ACT_STOP;
				end
			end
			CMD_CONTROL: begin
				if (d1 inside {CC_SOUND_OFF, CC_NOTES_OFF}) begin
					fire = 1'b1;
					act  = ACT_STOP;
				end
			end
			CMD_BEND: begin
				calc      = 1'b1;
				calc_bend = {d2, d1};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= T_IDLE;
			phase_q          <= PH_STATUS;
			status_q         <= '0;
			first_q          <= '0;
			out_valid_q      <= 1'b0;
			freq_req_q.start <= 1'b0;
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				note_q[c] <= '0;
				bend_q[c] <= BEND_CENTER;
			end
			for (int i = 0; i < NUM_GEN_USED; i++)
				gen_ch_q[i] <= GEN_RESET[i];
		end else begin
			freq_req_q.start <= 1'b0;
			// the result register is refilled in T_PUT
			if (out_valid_q && out_ready && state_q != T_PUT)
				out_valid_q <= 1'b0;

			for (int i = 0; i < NUM_GEN_USED; i++) begin
				if (cfg_valid && cfg_index == CFG_IDX_W'(i))
					gen_ch_q[i] <= cfg_data;
			end

			case (state_q)
				T_IDLE: begin
					if (in_valid) begin
						case (phase_q)
							PH_DATA1: begin
								phase_q <= PH_STATUS;
								// one-byte messages here never produce an item
								if (is_data && cmd != CMD_PROGRAM && cmd != CMD_PRESSURE) begin
									first_q <= d2;
									phase_q <= PH_DATA2;
								end
							end
							PH_DATA2: begin
								phase_q <= PH_STATUS;
								if (is_data) begin
									if (cmd == CMD_NOTE_ON && d2 != '0)
										note_q[ch] <= d1;
									if (cmd == CMD_BEND)
										bend_q[ch] <= {d2, d1};
									if ((calc || fire) && found) begin
										pend_gen_q <= gidx;
										pend_act_q <= act;
										if (calc) begin
											freq_req_q.start <= 1'b1;
											freq_req_q.note  <= calc_note;
											freq_req_q.bend  <= calc_bend;
											pend_load_q      <= 1'b1;
											state_q          <= T_CALC;
										end else begin
											pend_load_q <= 1'b0;
											pend_half_q <= '0;
											state_q     <= T_PUT;
										end
									end
								end
							end
							default: begin
								if (!is_data) begin
									status_q <= rx_byte[6:0];
									phase_q  <= PH_DATA1;
								end
							end
						endcase
					end
				end
				T_CALC: begin
					if (freq_rsp.done) begin
						pend_half_q <= freq_rsp.half;
						state_q     <= T_PUT;
					end
				end
				T_PUT: begin
					// hold until the result register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						gen_q       <= pend_gen_q;
						action_q    <= pend_act_q;
						load_q      <= pend_load_q;
						half_q      <= pend_half_q;
						state_q     <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign in_ready      = state_q == T_IDLE;
	assign cfg_ready     = 1'b1;
	assign out_valid     = out_valid_q;
	assign gen_index     = gen_q;
	assign enable_action = action_q;
	assign period_load   = load_q;
	assign half_period   = half_q;

	`MTPC_NEVER(a_freq_done_calc, clk, arst_n, freq_rsp.done && (state_q != T_CALC), "half period result outside calculation")
	`MTPC_ASSERT(a_load_half, clk, arst_n, out_valid_q |-> (load_q == (half_q != '0)), "half period does not agree with period load")
	`MTPC_ASSERT(a_noload_stop, clk, arst_n, (out_valid_q && !load_q) |-> (action_q == ACT_STOP), "item without period load is not a stop")

endmodule
